/* rtl/tfd_pkg.sv */
// Shared types and constants of the telemetry frame deframer.
`default_nettype none

package tfd_pkg;

  typedef enum logic {
    PhaseHunt,
    PhaseInFrame
  } phase_e;

  typedef enum logic {
    KindPayload,
    KindComplete
  } kind_e;

  localparam logic [7:0] MarkerReset = 8'd253;
  localparam logic [8:0] LenPos      = 9'd1;
  localparam logic [8:0] FirstHdrPos = 9'd2;
  localparam logic [8:0] HdrEnd      = 9'd10;
  // The last frame position is the second checksum byte after a full payload.
  localparam logic [8:0] MaxPos      = HdrEnd + 9'd256;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  payload_len;
    logic [7:0]  incompat_bits;
    logic [7:0]  compat_bits;
    logic [7:0]  sequence_res;
    logic [7:0]  system_id;
    logic [7:0]  component_id;
    logic [23:0] message_id;
    logic [15:0] frame_checksum;
  } result_t;

endpackage

`default_nettype wire

/* rtl/telemetry_frame_deframer.sv */
// Top level of the telemetry frame deframer.
//
// Link bytes enter on the in channel (in_valid_i, rx_byte_i, in_stall_o) and
// results leave on the out channel (out_valid_o, result fields, out_stall_i).
// A transaction completes at a clock edge where valid is high and stall low.
// Bytes are dropped until one matches the start marker; the frame then runs
// length + 12 bytes. Every payload byte gives one result, and the second
// checksum byte gives a frame complete result carrying header and checksum.
// A result shows on the out channel in the cycle after the byte that caused
// it was accepted. One byte is taken every cycle; the
// only limit is the single result register, so in_stall_o rises only while
// a result is held and out_stall_i is high.
// Reset puts the parser in the hunt, empties the result register and sets
// the start marker to 253. cfg_we_i writes cfg_data_i as the new marker and
// must only be used while no frame is in progress and no result is pending.
`default_nettype none

module telemetry_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [7:0]       payload_index_o,
  output logic [7:0]       payload_len_o,
  output logic [7:0]       incompat_bits_o,
  output logic [7:0]       compat_bits_o,
  output logic [7:0]       sequence_res_o,
  output logic [7:0]       system_id_o,
  output logic [7:0]       component_id_o,
  output logic [23:0]      message_id_o,
  output logic [15:0]      frame_checksum_o
);

  logic             ready;
  logic             step;
  logic             res_valid;
  tfd_pkg::result_t res;
  tfd_pkg::result_t out_res;

  assign in_stall_o = !ready;
  assign step       = in_valid_i && ready;

  tfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .rx_byte_i   (rx_byte_i),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  tfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o           = out_res.kind;
  assign payload_byte_o   = out_res.payload_byte;
  assign payload_index_o  = out_res.payload_index;
  assign payload_len_o    = out_res.payload_len;
  assign incompat_bits_o  = out_res.incompat_bits;
  assign compat_bits_o    = out_res.compat_bits;
  assign sequence_res_o   = out_res.sequence_res;
  assign system_id_o      = out_res.system_id;
  assign component_id_o   = out_res.component_id;
  assign message_id_o     = out_res.message_id;
  assign frame_checksum_o = out_res.frame_checksum;

endmodule

`default_nettype wire

/* rtl/tfd_parser.sv */
// Frame parser: start-marker hunt, position counter and header capture.
`default_nettype none

module tfd_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_data_i,
  input  wire logic            step_i,
  input  wire logic [7:0]      rx_byte_i,
  output tfd_pkg::result_t     res_o,
  output logic                 res_valid_o
);

  tfd_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       marker_q;
  logic [8:0]       pos_q, pos_d;
  logic [7:0]       len_q, len_d;
  logic [7:0][7:0]  hdr_q, hdr_d;
  logic [7:0]       ck_lo_q, ck_lo_d;

  logic [8:0] frame_end;
  logic [2:0] hdr_idx;
  logic       marker_hit, at_len, in_hdr, in_pay, at_ck_lo;

  assign frame_end  = tfd_pkg::HdrEnd + {1'b0, len_q};
  assign hdr_idx    = 3'(pos_q - tfd_pkg::FirstHdrPos);
  assign marker_hit = (rx_byte_i == marker_q);
  assign at_len     = (pos_q == tfd_pkg::LenPos);
  assign in_hdr     = (pos_q < tfd_pkg::HdrEnd);
  assign in_pay     = (pos_q < frame_end);
  assign at_ck_lo   = (pos_q == frame_end);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      tfd_pkg::PhaseHunt: begin
        if (step_i && marker_hit) begin
          phase_d = tfd_pkg::PhaseInFrame;
        end
      end
      tfd_pkg::PhaseInFrame: begin
        if (step_i && !at_len && !in_hdr && !in_pay && !at_ck_lo) begin
          phase_d = tfd_pkg::PhaseHunt;
        end
      end
      default: phase_d = tfd_pkg::PhaseHunt;
    endcase
  end

  // Field capture and results.
  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    hdr_d       = hdr_q;
    ck_lo_d     = ck_lo_q;
    res_valid_o = 1'b0;

    res_o               = '0;
    res_o.kind          = tfd_pkg::KindPayload;
    res_o.payload_len   = len_q;
    res_o.incompat_bits = hdr_q[0];
    res_o.compat_bits   = hdr_q[1];
    res_o.sequence_res  = hdr_q[2];
    res_o.system_id     = hdr_q[3];
    res_o.component_id  = hdr_q[4];
    res_o.message_id    = {hdr_q[7], hdr_q[6], hdr_q[5]};

    case (phase_q)
      tfd_pkg::PhaseHunt: begin
        if (step_i && marker_hit) begin
          pos_d   = tfd_pkg::LenPos;
          len_d   = '0;
          hdr_d   = '0;
          ck_lo_d = '0;
        end
      end
      tfd_pkg::PhaseInFrame: begin
        if (step_i) begin
          pos_d = pos_q + 9'd1;
          if (at_len) begin
            len_d = rx_byte_i;
          end else if (in_hdr) begin
            hdr_d[hdr_idx] = rx_byte_i;
          end else if (in_pay) begin
            res_valid_o         = 1'b1;
            res_o.payload_byte  = rx_byte_i;
            res_o.payload_index = 8'(pos_q - tfd_pkg::HdrEnd);
          end else if (at_ck_lo) begin
            ck_lo_d = rx_byte_i;
          end else begin
            res_valid_o          = 1'b1;
            res_o.kind           = tfd_pkg::KindComplete;
            res_o.frame_checksum = {rx_byte_i, ck_lo_q};
            pos_d                = '0;
          end
        end
      end
      default: pos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tfd_pkg::PhaseHunt;
      marker_q <= tfd_pkg::MarkerReset;
      pos_q    <= '0;
      len_q    <= '0;
      hdr_q    <= '0;
      ck_lo_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      hdr_q   <= hdr_d;
      ck_lo_q <= ck_lo_d;
      if (cfg_we_i) begin
        marker_q <= cfg_data_i;
      end
    end
  end

  a_hunt_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tfd_pkg::PhaseHunt |-> pos_q == '0)
    else $error("position counter not cleared while hunting");

  a_frame_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tfd_pkg::PhaseInFrame |-> pos_q != '0 && pos_q <= tfd_pkg::MaxPos)
    else $error("frame position out of range");

  a_complete_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == tfd_pkg::KindComplete |=> phase_q == tfd_pkg::PhaseHunt)
    else $error("frame complete result without return to hunting");

  a_no_result_hunting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tfd_pkg::PhaseHunt |-> !res_valid_o)
    else $error("result produced while hunting");

endmodule

`default_nettype wire

/* rtl/tfd_out_reg.sv */
// Result register that holds one result while the receiver stalls.
`default_nettype none

module tfd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire tfd_pkg::result_t res_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tfd_pkg::result_t      res_o
);

  logic             valid_q, valid_d;
  tfd_pkg::result_t data_q;

  // A new transaction may enter when the register is empty or being emptied.
  assign ready_o     = !valid_q || !out_stall_i;
  assign valid_d     = res_valid_i || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign res_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      data_q <= res_i;
    end
  end

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ready_o)
    else $error("result written over a stalled result");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |=> out_valid_o && res_o == $past(res_i))
    else $error("loaded result not presented");

  a_drain_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !res_valid_i |=> !out_valid_o)
    else $error("taken result still presented");

endmodule

`default_nettype wire
